FILE: design/mqd_pkg.sv
// Shared constants, types and a phase helper for the multi quadrature decoder.
`default_nettype none
package mqd_pkg;

    localparam int NUM_ENC  = 5;
    localparam int COUNT_W  = 32;
    localparam int PINS_PER = 3;
    localparam int SAMPLE_W = PINS_PER * NUM_ENC;

    localparam logic [1:0] PHASE_MASK = 2'h3;
    localparam int         INDEX_POS  = 2;

    typedef logic [1:0]         phase_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        count_t count;
        logic   seen;
        logic   missed;
    } chan_res_t;

    // Next phase in the counting-up direction: 0->1, 1->3, 3->2, 2->0
    function automatic phase_t phase_up(input phase_t p);
        phase_t r;
        unique case (p)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd3;
            2'd3:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: design/mqd_channel.sv
// One encoder channel: phase history, position count and sticky index flag.
`default_nettype none
module mqd_channel (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               update,
    input  wire logic               primed,
    input  wire logic [2:0]         pin_bits,
    output mqd_pkg::chan_res_t      res
);
    import mqd_pkg::*;

    phase_t prev_reg, prev_next;
    count_t count_reg, count_next;
    logic   seen_reg, seen_next;
    logic   missed;
    phase_t now;
    logic   index;

    assign now   = pin_bits[1:0] & PHASE_MASK;
    assign index = pin_bits[INDEX_POS];

    always_comb
    begin
        prev_next  = now;
        count_next = count_reg;
        seen_next  = seen_reg;
        missed     = 1'b0;
        if (primed)
        begin
            if (index)
            begin
                count_next = '0;
                seen_next  = 1'b1;
            end
            else if (now == phase_up(prev_reg))
            begin
                count_next = count_reg + count_t'(1);
            end
            else if (prev_reg == phase_up(now))
            begin
                count_next = count_reg - count_t'(1);
            end
            else if (now == (prev_reg ^ PHASE_MASK))
            begin
                missed = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            count_reg <= '0;
            seen_reg  <= 1'b0;
        end
        else if (update)
        begin
            prev_reg  <= prev_next;
            count_reg <= count_next;
            seen_reg  <= seen_next;
        end
    end

    assign res.count  = count_next;
    assign res.seen   = seen_next;
    assign res.missed = missed;

endmodule
`default_nettype wire

FILE: design/multi_quadrature_decoder.sv
// Top level of the five-channel quadrature decoder with index inputs.
// One pin sample is taken per transfer and one result follows for each, at a
// sustained rate of one sample per clock while the output is not stalled; each
// sample passes through the input register, then the per-channel update into
// the result register. While a result is stalled one further sample is held
// in the input register. The first
// sample after reset only loads the phase history; after that Gray steps count
// up or down, a two-state jump flags missed, and an index pulse clears the
// count and sets the sticky indexed flag.
`default_nettype none
module multi_quadrature_decoder (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [14:0]        pin_sample,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      count_one,
    output logic signed [31:0]      count_two,
    output logic signed [31:0]      count_three,
    output logic signed [31:0]      count_four,
    output logic signed [31:0]      count_five,
    output logic [4:0]              indexed_mask,
    output logic [4:0]              missed_mask
);
    import mqd_pkg::*;

    logic                s1_valid_reg, s1_valid_next;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                primed_reg;
    logic                out_valid_reg, out_valid_next;
    logic                advance;
    logic                in_xfer;

    chan_res_t           res [NUM_ENC];
    count_t              count_reg [NUM_ENC];
    logic [NUM_ENC-1:0]  indexed_reg, missed_reg;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    assign s1_valid_next  = in_xfer || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            primed_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                primed_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            s1_sample_reg <= pin_sample;
    end

    genvar k;
    generate
        for (k = 0; k < NUM_ENC; k++)
        begin : g_chan
            mqd_channel u_chan (
                .clk      (clk),
                .rst_n    (rst_n),
                .update   (advance),
                .primed   (primed_reg),
                .pin_bits (s1_sample_reg[PINS_PER*k +: PINS_PER]),
                .res      (res[k])
            );

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    count_reg[k]   <= res[k].count;
                    indexed_reg[k] <= res[k].seen;
                    missed_reg[k]  <= res[k].missed;
                end
            end
        end
    endgenerate

    assign out_valid    = out_valid_reg;
    assign count_one    = count_reg[0];
    assign count_two    = count_reg[1];
    assign count_three  = count_reg[2];
    assign count_four   = count_reg[3];
    assign count_five   = count_reg[4];
    assign indexed_mask = indexed_reg;
    assign missed_mask  = missed_reg;

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the five-channel quadrature decoder with index inputs.
`timescale 1ns / 1ps
module tb;
    import mqd_pkg::*;

    typedef struct packed {
        count_t [NUM_ENC-1:0] cnt;
        logic   [NUM_ENC-1:0] idx;
        logic   [NUM_ENC-1:0] mis;
    } dec_res_t;

    // Rows marked fixed expect every count clear plus the given masks
    typedef struct {
        logic [SAMPLE_W-1:0] pins;
        bit                  fixed;
        logic [NUM_ENC-1:0]  idx;
        logic [NUM_ENC-1:0]  mis;
    } dir_row_t;

    typedef enum logic [1:0] { ST_NONE, ST_COIN, ST_HOLD, ST_EVERY3 } stall_mode_t;

    localparam int     N_RANDOM   = 2000;
    localparam int     IDLE_LIMIT = 1000;
    localparam phase_t GRAY_FWD [4] = '{2'd1, 2'd3, 2'd0, 2'd2};
    localparam phase_t GRAY_BWD [4] = '{2'd2, 2'd0, 2'd3, 2'd1};

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic [SAMPLE_W-1:0]  pin_sample = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic signed [31:0]   count_one;
    logic signed [31:0]   count_two;
    logic signed [31:0]   count_three;
    logic signed [31:0]   count_four;
    logic signed [31:0]   count_five;
    logic [NUM_ENC-1:0]   indexed_mask;
    logic [NUM_ENC-1:0]   missed_mask;

    multi_quadrature_decoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pin_sample   (pin_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .count_one    (count_one),
        .count_two    (count_two),
        .count_three  (count_three),
        .count_four   (count_four),
        .count_five   (count_five),
        .indexed_mask (indexed_mask),
        .missed_mask  (missed_mask)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Decoder state mirror
    phase_t             last_ph [NUM_ENC];
    count_t             pos_cnt [NUM_ENC];
    logic [NUM_ENC-1:0] idx_seen;
    bit                 armed;

    dec_res_t           counts_q [$];
    dir_row_t           dir_tab [$];
    int                 fail_cnt   = 0;
    int                 idle_cyc   = 0;
    int                 burst_left = 0;
    int                 gap_len    = 0;

    function automatic dec_res_t decode_sample(input logic [SAMPLE_W-1:0] pins);
        dec_res_t r;
        phase_t   now;
        logic     idx_bit;
        r.mis = '0;
        for (int k = 0; k < NUM_ENC; k++)
        begin
            now     = pins[PINS_PER*k +: 2];
            idx_bit = pins[PINS_PER*k + INDEX_POS];
            if (armed)
            begin
                if (idx_bit)
                begin
                    pos_cnt[k]  = '0;
                    idx_seen[k] = 1'b1;
                end
                else if (now == GRAY_FWD[last_ph[k]])
                    pos_cnt[k] = pos_cnt[k] + count_t'(1);
                else if (last_ph[k] == GRAY_FWD[now])
                    pos_cnt[k] = pos_cnt[k] - count_t'(1);
                else if (now == (last_ph[k] ^ PHASE_MASK))
                    r.mis[k] = 1'b1;
            end
            last_ph[k] = now;
        end
        armed = 1'b1;
        for (int k = 0; k < NUM_ENC; k++)
            r.cnt[k] = pos_cnt[k];
        r.idx = idx_seen;
        return r;
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] v, input bit fixed,
                               input logic [NUM_ENC-1:0] w_idx,
                               input logic [NUM_ENC-1:0] w_mis);
        dec_res_t p;
        if (burst_left == 0)
        begin
            gap_len    = $urandom_range(0, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            if (gap_len > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap_len) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        pin_sample <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        p = decode_sample(v);
        if (fixed)
        begin
            p.cnt = '0;
            p.idx = w_idx;
            p.mis = w_mis;
        end
        counts_q.push_back(p);
    endtask

    // Receiver back-pressure
    stall_mode_t smode     = ST_NONE;
    int          mode_left = 0;
    int          hold_left = 0;
    int          cyc3      = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (mode_left == 0)
            begin
                smode     <= stall_mode_t'($urandom_range(0, 3));
                mode_left <= $urandom_range(20, 200);
            end
            else
                mode_left <= mode_left - 1;
            cyc3 <= (cyc3 == 2) ? 0 : cyc3 + 1;
            case (smode)
                ST_NONE:   out_stall <= 1'b0;
                ST_COIN:   out_stall <= 1'($urandom_range(0, 1));
                ST_EVERY3: out_stall <= (cyc3 == 0);
                default:
                begin
                    if (hold_left > 0)
                    begin
                        out_stall <= 1'b1;
                        hold_left <= hold_left - 1;
                    end
                    else if ($urandom_range(0, 7) == 0)
                    begin
                        out_stall <= 1'b1;
                        hold_left <= $urandom_range(1, 30);
                    end
                    else
                        out_stall <= 1'b0;
                end
            endcase
        end
    end

    always @(posedge clk)
    begin : result_check
        dec_res_t act;
        dec_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            act.cnt[0] = count_one;
            act.cnt[1] = count_two;
            act.cnt[2] = count_three;
            act.cnt[3] = count_four;
            act.cnt[4] = count_five;
            act.idx    = indexed_mask;
            act.mis    = missed_mask;
            if (counts_q.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected result: cnt %h %h %h %h %h idx %b mis %b",
                             act.cnt[0], act.cnt[1], act.cnt[2], act.cnt[3], act.cnt[4],
                             act.idx, act.mis);
            end
            else
            begin
                want = counts_q.pop_front();
                if (act.cnt !== want.cnt || act.idx !== want.idx || act.mis !== want.mis)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                    begin
                        $display("mismatch exp: cnt %h %h %h %h %h idx %b mis %b",
                                 want.cnt[0], want.cnt[1], want.cnt[2], want.cnt[3],
                                 want.cnt[4], want.idx, want.mis);
                        $display("         got: cnt %h %h %h %h %h idx %b mis %b",
                                 act.cnt[0], act.cnt[1], act.cnt[2], act.cnt[3],
                                 act.cnt[4], act.idx, act.mis);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cyc <= 0;
            else if (idle_cyc == IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
                idle_cyc <= idle_cyc + 1;
        end
    end

    initial
    begin : stim
        logic [SAMPLE_W-1:0] v;
        logic [SAMPLE_W-1:0] prev_pins;
        phase_t              ph;
        phase_t              nph;
        logic                ib;
        int                  r;

        for (int k = 0; k < NUM_ENC; k++)
        begin
            last_ph[k] = '0;
            pos_cnt[k] = '0;
        end
        idx_seen = '0;
        armed    = 1'b0;

        dir_tab.push_back('{15'h7FFF, 1'b1, 5'h00, 5'h00}); // first sample primes only
        dir_tab.push_back('{15'h0000, 1'b1, 5'h00, 5'h1F}); // jump on every channel
        dir_tab.push_back('{15'h0000, 1'b1, 5'h00, 5'h00}); // unchanged
        dir_tab.push_back('{15'h1249, 1'b0, 5'h00, 5'h00}); // up 0-1-3-2-0
        dir_tab.push_back('{15'h36DB, 1'b0, 5'h00, 5'h00});
        dir_tab.push_back('{15'h2492, 1'b0, 5'h00, 5'h00});
        dir_tab.push_back('{15'h0000, 1'b0, 5'h00, 5'h00});
        dir_tab.push_back('{15'h2492, 1'b0, 5'h00, 5'h00}); // down
        dir_tab.push_back('{15'h4924, 1'b1, 5'h1F, 5'h00}); // index everywhere
        dir_tab.push_back('{15'h7FFF, 1'b1, 5'h1F, 5'h00}); // index masks the jump
        dir_tab.push_back('{15'h760A, 1'b0, 5'h00, 5'h00}); // up, down, jump, hold, index
        dir_tab.push_back('{15'h0000, 1'b0, 5'h00, 5'h00});
        dir_tab.push_back('{15'h2492, 1'b0, 5'h00, 5'h00}); // down through zero: wrap
        dir_tab.push_back('{15'h36DB, 1'b0, 5'h00, 5'h00});
        dir_tab.push_back('{15'h1249, 1'b0, 5'h00, 5'h00});
        dir_tab.push_back('{15'h0000, 1'b0, 5'h00, 5'h00});
        dir_tab.push_back('{15'h2AAA, 1'b0, 5'h00, 5'h00});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < dir_tab.size(); i++)
            send_sample(dir_tab[i].pins, dir_tab[i].fixed, dir_tab[i].idx, dir_tab[i].mis);
        prev_pins = dir_tab[dir_tab.size()-1].pins;

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                v = SAMPLE_W'($urandom_range(0, 32767));
            else
            begin
                v = '0;
                for (int k = 0; k < NUM_ENC; k++)
                begin
                    ph = prev_pins[PINS_PER*k +: 2];
                    ib = 1'b0;
                    r  = $urandom_range(0, 99);
                    if (r < 40)
                        nph = GRAY_FWD[ph];
                    else if (r < 75)
                        nph = GRAY_BWD[ph];
                    else if (r < 88)
                        nph = ph;
                    else if (r < 95)
                        nph = ph ^ PHASE_MASK;
                    else
                    begin
                        nph = phase_t'($urandom_range(0, 3));
                        ib  = 1'b1;
                    end
                    v[PINS_PER*k +: 2]       = nph;
                    v[PINS_PER*k + INDEX_POS] = ib;
                end
            end
            send_sample(v, 1'b0, '0, '0);
            prev_pins = v;
            if (n == 700 || n == 1400)
            begin
                // let the pipeline drain completely
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (counts_q.size() != 0);
            end
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (counts_q.size() != 0);
        repeat (4) @(posedge clk);

        if (fail_cnt == 0 && counts_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
